// ===== hdl/lagged_state_space_simulator_top_assert.svh =====
// Assertion macros shared by the simulator RTL.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef LAGGED_STATE_SPACE_SIMULATOR_TOP_ASSERT_SVH
`define LAGGED_STATE_SPACE_SIMULATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LSSS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsss assertion failed");
`define LSSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsss assertion failed");
`else
`define LSSS_ASSERT_SAME(label, ante, cons)
`define LSSS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/lsss_pkg.sv =====
// Shared types, codes and arithmetic helpers of the lagged state-space simulator.
// No dependencies; the lane, merge and top files import this package.
package lsss_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * DATA_W - FRAC_W;
   localparam int N_IN_SERIES = 2;
   localparam int N_CFG_REGS = 4;
   localparam int CFG_W = 5;
   localparam int CSR_INDEX_W = $clog2(N_CFG_REGS);

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   localparam data_type DATA_MAX = 32'sh7FFF_FFFF;
   localparam data_type DATA_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      CMD_LOAD_COEF  = 2'd0,
      CMD_LOAD_STATE = 2'd1,
      CMD_SIMULATE   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      MAT_TRANSITION  = 2'd0,
      MAT_MEASUREMENT = 2'd1,
      MAT_PERSISTENCE = 2'd2
   } mat_sel_type;

   typedef struct packed {
      logic [1:0] command;
      logic [1:0] matrix_select;
      logic [1:0] row_index;
      logic [1:0] col_index;
      logic [4:0] state_age;
      logic signed [31:0] load_value;
      logic signed [31:0] error_series0;
      logic signed [31:0] error_series1;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] actual_series0;
      logic signed [31:0] actual_series1;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic adv1;
      logic adv2;
   } pipe_type;

   typedef struct packed {
      logic en;
      logic [1:0] sel;
      logic [1:0] row;
      logic [1:0] col;
      data_type value;
   } coef_wr_type;

   // Q16.16 product; the arithmetic shift drops the low bits toward minus infinity.
   function automatic prod_type qmul(input data_type a, input data_type b);
      logic signed [2*DATA_W-1:0] full;
      full = (2*DATA_W)'(a) * (2*DATA_W)'(b);
      return full[2*DATA_W-1:FRAC_W];
   endfunction

endpackage

// ===== hdl/lsss_stream_if.sv =====
// Valid/ready channel that carries one beat of a payload struct.
// Payload types come from lsss_pkg.
interface lsss_stream_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/lsss_lane.sv =====
// One component lane: its state history memory, its columns of the transition
// and measurement matrices, and their products with the lagged state. Uses lsss_pkg.
module lsss_lane
   import lsss_pkg::*;
#(
   parameter int N_COMP = 4,
   parameter int N_SERIES = 2,
   parameter int MAX_LAG = 16,
   parameter int LANE = 0,
   localparam int SLOT_W = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  pipe_type          pipe,
   input  coef_wr_type       coef_wr,
   input  logic [SLOT_W-1:0] rd_slot,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_slot,
   input  data_type          wr_data,
   output prod_type          f_prod [N_COMP],
   output prod_type          w_prod [N_SERIES]
);

   data_type hist_mem_ff [MAX_LAG];
   logic [MAX_LAG-1:0] written_ff;
   data_type x_raw_ff;
   logic x_valid_ff;
   data_type x_value;
   data_type f_col_ff [N_COMP];
   data_type w_col_ff [N_SERIES];
   prod_type f_prod_ff [N_COMP];
   prod_type w_prod_ff [N_SERIES];
   logic col_hit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem_ff[wr_slot] <= wr_data;
      end
      if (pipe.capture) begin
         x_raw_ff <= hist_mem_ff[rd_slot];
      end
   end

   // An entry that was never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         x_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_slot] <= 1'b1;
         end
         if (pipe.capture) begin
            x_valid_ff <= written_ff[rd_slot];
         end
      end
   end

   assign x_value = x_valid_ff ? x_raw_ff : '0;
   assign col_hit = (int'(coef_wr.col) == LANE);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < N_COMP; r++) begin
            f_col_ff[r] <= '0;
         end
         for (int s = 0; s < N_SERIES; s++) begin
            w_col_ff[s] <= '0;
         end
      end else if (coef_wr.en && col_hit) begin
         for (int r = 0; r < N_COMP; r++) begin
            if (coef_wr.sel == MAT_TRANSITION && int'(coef_wr.row) == r) begin
               f_col_ff[r] <= coef_wr.value;
            end
         end
         for (int s = 0; s < N_SERIES; s++) begin
            if (coef_wr.sel == MAT_MEASUREMENT && int'(coef_wr.row) == s) begin
               w_col_ff[s] <= coef_wr.value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe.adv1) begin
         for (int r = 0; r < N_COMP; r++) begin
            f_prod_ff[r] <= qmul(f_col_ff[r], x_value);
         end
         for (int s = 0; s < N_SERIES; s++) begin
            w_prod_ff[s] <= qmul(w_col_ff[s], x_value);
         end
      end
   end

   assign f_prod = f_prod_ff;
   assign w_prod = w_prod_ff;

endmodule

// ===== hdl/lsss_merge.sv =====
// Merging stage: persistence products, sums of the lane products and error
// terms, and saturation to 32 bits. Uses lsss_pkg.
module lsss_merge
   import lsss_pkg::*;
#(
   parameter int N_COMP = 4,
   parameter int N_SERIES = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  pipe_type    pipe,
   input  coef_wr_type coef_wr,
   input  data_type    error_in [N_IN_SERIES],
   input  prod_type    f_prod [N_COMP][N_COMP],
   input  prod_type    w_prod [N_COMP][N_SERIES],
   output data_type    y_sat [N_SERIES],
   output data_type    nx_sat [N_COMP]
);

   localparam int SUM_W = PROD_W + $clog2(N_COMP + N_SERIES) + 1;

   typedef logic signed [SUM_W-1:0] sum_type;

   data_type g_ff [N_COMP][N_SERIES];
   data_type e1_ff [N_SERIES];
   data_type e2_ff [N_SERIES];
   prod_type g_prod_ff [N_COMP][N_SERIES];
   sum_type y_sum_ff [N_SERIES];
   sum_type nx_sum_ff [N_COMP];
   sum_type y_sum_in [N_SERIES];
   sum_type nx_sum_in [N_COMP];

   function automatic data_type saturate(input sum_type v);
      if (v[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){v[SUM_W-1]}}) begin
         return v[DATA_W-1:0];
      end else if (v[SUM_W-1]) begin
         return DATA_MIN;
      end else begin
         return DATA_MAX;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < N_COMP; c++) begin
            for (int s = 0; s < N_SERIES; s++) begin
               g_ff[c][s] <= '0;
            end
         end
      end else if (coef_wr.en && coef_wr.sel == MAT_PERSISTENCE) begin
         for (int c = 0; c < N_COMP; c++) begin
            for (int s = 0; s < N_SERIES; s++) begin
               if (int'(coef_wr.row) == c && int'(coef_wr.col) == s) begin
                  g_ff[c][s] <= coef_wr.value;
               end
            end
         end
      end
   end

   // Series without an error input carry a zero error term.
   always_ff @(posedge clock) begin
      if (pipe.capture) begin
         for (int s = 0; s < N_SERIES; s++) begin
            if (s < N_IN_SERIES) begin
               e1_ff[s] <= error_in[s];
            end else begin
               e1_ff[s] <= '0;
            end
         end
      end
      if (pipe.adv1) begin
         for (int s = 0; s < N_SERIES; s++) begin
            e2_ff[s] <= e1_ff[s];
            for (int c = 0; c < N_COMP; c++) begin
               g_prod_ff[c][s] <= qmul(g_ff[c][s], e1_ff[s]);
            end
         end
      end
      if (pipe.adv2) begin
         y_sum_ff <= y_sum_in;
         nx_sum_ff <= nx_sum_in;
      end
   end

   always_comb begin
      for (int s = 0; s < N_SERIES; s++) begin
         y_sum_in[s] = SUM_W'(e2_ff[s]);
         for (int k = 0; k < N_COMP; k++) begin
            y_sum_in[s] = y_sum_in[s] + SUM_W'(w_prod[k][s]);
         end
      end
      for (int c = 0; c < N_COMP; c++) begin
         nx_sum_in[c] = '0;
         for (int k = 0; k < N_COMP; k++) begin
            nx_sum_in[c] = nx_sum_in[c] + SUM_W'(f_prod[k][c]);
         end
         for (int s = 0; s < N_SERIES; s++) begin
            nx_sum_in[c] = nx_sum_in[c] + SUM_W'(g_prod_ff[c][s]);
         end
      end
   end

   always_comb begin
      for (int s = 0; s < N_SERIES; s++) begin
         y_sat[s] = saturate(y_sum_ff[s]);
      end
      for (int c = 0; c < N_COMP; c++) begin
         nx_sat[c] = saturate(nx_sum_ff[c]);
      end
   end

endmodule

// ===== hdl/lagged_state_space_simulator_top.sv =====
// Top level of the lagged state-space simulator: lag registers, time pointer, pipeline
// control and output register around the lanes and the merging stage. Uses lsss_pkg.
// A simulate beat passes stages s1, s2 and s3 and then the response register; back-pressure can hold it.
// Throughput: one beat per cycle while every component lag is at least four and the response is taken; a beat whose
// lagged state is still in flight waits for its write; with a lag of one each step waits for the previous write.
// Reset is synchronous: coefficients, time pointer and pipeline clear at once; history entries read as zero.
`include "lagged_state_space_simulator_top_assert.svh"
module lagged_state_space_simulator_top
   import lsss_pkg::*;
#(
   parameter int N_COMP = 4,
   parameter int N_SERIES = 2,
   parameter int MAX_LAG = 16
) (
   input logic                   clock,
   input logic                   reset,
   lsss_stream_if.sink           req_stream,
   lsss_stream_if.source         rsp_stream,
   input logic                   csr_write_enable,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CFG_W-1:0]       csr_write_data
);

   localparam int SLOT_W = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;

   typedef struct packed {
      logic sim;
      logic state_ld;
      logic coef_ld;
      logic [1:0] sel;
      logic [1:0] row;
      logic [1:0] col;
      logic [SLOT_W-1:0] slot;
      data_type value;
   } stage_type;

   logic [CFG_W-1:0] lag_ff [N_COMP];
   logic [SLOT_W-1:0] tp_ff;
   logic [SLOT_W-1:0] tp_in;
   logic s1_v_ff;
   logic s2_v_ff;
   logic s3_v_ff;
   stage_type s1_ff;
   stage_type s2_ff;
   stage_type s3_ff;
   stage_type stage_in;
   logic adv1;
   logic adv2;
   logic adv3;
   logic hazard;
   pipe_type pipe;
   coef_wr_type coef_wr;
   logic [SLOT_W-1:0] rd_slot [N_COMP];
   logic [N_COMP-1:0] wr_en;
   logic [N_COMP-1:0] rd_wr_clash;
   data_type wr_data [N_COMP];
   data_type error_in [N_IN_SERIES];
   prod_type f_prod [N_COMP][N_COMP];
   prod_type w_prod [N_COMP][N_SERIES];
   data_type y_sat [N_SERIES];
   data_type nx_sat [N_COMP];
   logic rsp_valid_ff;
   data_type rsp_obs_ff [N_IN_SERIES];
   data_type obs_in [N_IN_SERIES];

   function automatic logic [SLOT_W:0] clamp_lag(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return (SLOT_W+1)'(1);
      end else if (int'(v) > MAX_LAG) begin
         return (SLOT_W+1)'(MAX_LAG);
      end else begin
         return (SLOT_W+1)'(v);
      end
   endfunction

   function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] tp,
                                                   input logic [SLOT_W:0] steps_back);
      logic [SLOT_W:0] diff;
      diff = {1'b0, tp} + (SLOT_W+1)'(MAX_LAG) - steps_back;
      if (diff >= (SLOT_W+1)'(MAX_LAG)) begin
         diff = diff - (SLOT_W+1)'(MAX_LAG);
      end
      return diff[SLOT_W-1:0];
   endfunction

   function automatic logic stage_clash(input logic v, input stage_type st,
                                        input int comp, input logic [SLOT_W-1:0] slot);
      return v && (st.sim || (st.state_ld && int'(st.row) == comp)) && (st.slot == slot);
   endfunction

   // Lag registers; components without a register keep a lag of one.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < N_COMP; c++) begin
            lag_ff[c] <= CFG_W'(1);
         end
      end else if (csr_write_enable) begin
         for (int c = 0; c < N_COMP; c++) begin
            if (c < N_CFG_REGS && int'(csr_index) == c) begin
               lag_ff[c] <= csr_write_data;
            end
         end
      end
   end

   always_comb begin
      hazard = 1'b0;
      for (int c = 0; c < N_COMP; c++) begin
         rd_slot[c] = slot_back(tp_ff, clamp_lag(lag_ff[c]));
         rd_wr_clash[c] = wr_en[c] && (s3_ff.slot == rd_slot[c]);
         if (stage_clash(s1_v_ff, s1_ff, c, rd_slot[c]) ||
             stage_clash(s2_v_ff, s2_ff, c, rd_slot[c]) ||
             stage_clash(s3_v_ff, s3_ff, c, rd_slot[c])) begin
            hazard = 1'b1;
         end
      end
   end

   assign adv3 = s3_v_ff && (!s3_ff.sim || !rsp_valid_ff || rsp_stream.ready);
   assign adv2 = s2_v_ff && (!s3_v_ff || adv3);
   assign adv1 = s1_v_ff && (!s2_v_ff || adv2);

   assign req_stream.ready = (!s1_v_ff || adv1) && !hazard;

   assign pipe.capture = req_stream.valid && req_stream.ready;
   assign pipe.adv1 = adv1;
   assign pipe.adv2 = adv2;

   always_comb begin
      stage_in.sim = (req_stream.payload.command == CMD_SIMULATE);
      stage_in.state_ld = (req_stream.payload.command == CMD_LOAD_STATE) &&
                          (int'(req_stream.payload.row_index) < N_COMP);
      stage_in.coef_ld = (req_stream.payload.command == CMD_LOAD_COEF);
      stage_in.sel = req_stream.payload.matrix_select;
      stage_in.row = req_stream.payload.row_index;
      stage_in.col = req_stream.payload.col_index;
      stage_in.value = req_stream.payload.load_value;
      if (stage_in.sim) begin
         stage_in.slot = tp_ff;
      end else begin
         stage_in.slot = slot_back(tp_ff, clamp_lag(req_stream.payload.state_age));
      end
   end

   assign tp_in = (int'(tp_ff) == MAX_LAG - 1) ? '0 : tp_ff + SLOT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff <= '0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (pipe.capture && stage_in.sim) begin
            tp_ff <= tp_in;
         end
         if (pipe.capture) begin
            s1_v_ff <= 1'b1;
         end else if (adv1) begin
            s1_v_ff <= 1'b0;
         end
         if (adv1) begin
            s2_v_ff <= 1'b1;
         end else if (adv2) begin
            s2_v_ff <= 1'b0;
         end
         if (adv2) begin
            s3_v_ff <= 1'b1;
         end else if (adv3) begin
            s3_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe.capture) begin
         s1_ff <= stage_in;
      end
      if (adv1) begin
         s2_ff <= s1_ff;
      end
      if (adv2) begin
         s3_ff <= s2_ff;
      end
   end

   // Coefficient loads take effect as they leave the first stage, in beat order.
   always_comb begin
      coef_wr.en = adv1 && s1_ff.coef_ld;
      coef_wr.sel = s1_ff.sel;
      coef_wr.row = s1_ff.row;
      coef_wr.col = s1_ff.col;
      coef_wr.value = s1_ff.value;
   end

   always_comb begin
      for (int c = 0; c < N_COMP; c++) begin
         wr_en[c] = adv3 && (s3_ff.sim || (s3_ff.state_ld && int'(s3_ff.row) == c));
         wr_data[c] = s3_ff.sim ? nx_sat[c] : s3_ff.value;
      end
   end

   assign error_in[0] = req_stream.payload.error_series0;
   assign error_in[1] = req_stream.payload.error_series1;

   for (genvar c = 0; c < N_COMP; c++) begin : g_lane
      lsss_lane #(
         .N_COMP   (N_COMP),
         .N_SERIES (N_SERIES),
         .MAX_LAG  (MAX_LAG),
         .LANE     (c)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .pipe    (pipe),
         .coef_wr (coef_wr),
         .rd_slot (rd_slot[c]),
         .wr_en   (wr_en[c]),
         .wr_slot (s3_ff.slot),
         .wr_data (wr_data[c]),
         .f_prod  (f_prod[c]),
         .w_prod  (w_prod[c])
      );
   end

   lsss_merge #(
      .N_COMP   (N_COMP),
      .N_SERIES (N_SERIES)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .pipe     (pipe),
      .coef_wr  (coef_wr),
      .error_in (error_in),
      .f_prod   (f_prod),
      .w_prod   (w_prod),
      .y_sat    (y_sat),
      .nx_sat   (nx_sat)
   );

   always_comb begin
      for (int s = 0; s < N_IN_SERIES; s++) begin
         if (s < N_SERIES) begin
            obs_in[s] = y_sat[s];
         end else begin
            obs_in[s] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv3 && s3_ff.sim) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_stream.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && s3_ff.sim) begin
         rsp_obs_ff <= obs_in;
      end
   end

   assign rsp_stream.valid = rsp_valid_ff;
   assign rsp_stream.payload.actual_series0 = rsp_obs_ff[0];
   assign rsp_stream.payload.actual_series1 = rsp_obs_ff[1];

   `LSSS_ASSERT_NEXT(a_result_only_from_final_stage, !rsp_valid_ff && !(adv3 && s3_ff.sim), !rsp_valid_ff)
   `LSSS_ASSERT_SAME(a_held_beat_not_overwritten, rsp_valid_ff && !rsp_stream.ready, !(adv3 && s3_ff.sim))
   `LSSS_ASSERT_SAME(a_no_read_during_write, pipe.capture, rd_wr_clash == '0)
   `LSSS_ASSERT_SAME(a_first_stage_free_on_accept, pipe.capture, !s1_v_ff || adv1)

endmodule
